// File: src/rsz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsz_pkg;
   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_WIDTH    = 64;
   localparam int MAX_CHANNELS = 4;
   localparam int FRAC_BITS    = 16;

   localparam int CH_W       = 2;
   localparam int IDX_W      = 8;
   localparam int PIX_W      = 8;
   localparam int SIZE_W     = 7;
   localparam int RATIO_W    = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int BANK_AW = CH_AW + (ROW_W - 1) + (COL_W - 1);
   localparam int BANK_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH / 4;

   localparam int PROD_W = IDX_W + RATIO_W + 1;
   localparam int COORD_W = PROD_W + 1;
   localparam int WGT_W  = FRAC_BITS + 1;
   localparam int ROWSUM_W = PIX_W + FRAC_BITS;
   localparam int SUM_W  = ROWSUM_W + WGT_W;

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef enum logic {
      MODE_BILINEAR = 1'b0,
      MODE_NEAREST  = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_SRC_WIDTH  = 3'd2,
      CSR_RATIO_Y    = 3'd3,
      CSR_RATIO_X    = 3'd4
   } csr_index_type;
endpackage
`default_nettype wire

// File: src/rsz_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rsz_req_if;
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [rsz_pkg::CH_W-1:0]     channel;
   logic [rsz_pkg::IDX_W-1:0]    row;
   logic [rsz_pkg::IDX_W-1:0]    col;
   logic [rsz_pkg::PIX_W-1:0]    pixel_in;

   modport source (output valid, operation, channel, row, col, pixel_in, input ready);
   modport sink (input valid, operation, channel, row, col, pixel_in, output ready);
endinterface
`default_nettype wire

// File: src/rsz_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rsz_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rsz_pkg::CH_W-1:0]     out_channel;
   logic [rsz_pkg::IDX_W-1:0]    out_row;
   logic [rsz_pkg::IDX_W-1:0]    out_col;
   logic [rsz_pkg::PIX_W-1:0]    pixel_out;

   modport source (output valid, out_channel, out_row, out_col, pixel_out, input ready);
   modport sink (input valid, out_channel, out_row, out_col, pixel_out, output ready);
endinterface
`default_nettype wire

// File: src/rsz_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rsz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: src/image_resize_sampler.sv
`timescale 1ns / 1ps
`default_nettype none
// Bilinear / nearest image scaler. Write transfers (operation 0) load one source pixel into
// four parity banks (row LSB, column LSB); request transfers (operation 1) return one
// destination pixel. One transfer is taken every clock while the result side keeps up;
// a request passes stage 1, stage 2 (bank read), stage 3 and the output register. All four
// neighbours are read together, one from each bank, so the banks set the one-item-per-clock
// rate. A write reaches the store at the pipeline step where requests read it, so results
// always see the writes that came before them. Store contents are undefined until written.
module image_resize_sampler (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rsz_req_if.sink                             req_chan,
   rsz_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_wr_en,
   input  wire logic [rsz_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rsz_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import rsz_pkg::*;

   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

   // configuration
   mode_type             mode_ff;
   logic [SIZE_W-1:0]    height_ff, width_ff;
   logic [RATIO_W-1:0]   ratio_y_ff, ratio_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_BILINEAR;
         height_ff  <= SIZE_W'(64);
         width_ff   <= SIZE_W'(64);
         ratio_y_ff <= RATIO_W'(65536);
         ratio_x_ff <= RATIO_W'(65536);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:       mode_ff    <= mode_type'(csr_wr_data[0]);
            CSR_SRC_HEIGHT: height_ff  <= csr_wr_data[SIZE_W-1:0];
            CSR_SRC_WIDTH:  width_ff   <= csr_wr_data[SIZE_W-1:0];
            CSR_RATIO_Y:    ratio_y_ff <= csr_wr_data[RATIO_W-1:0];
            CSR_RATIO_X:    ratio_x_ff <= csr_wr_data[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0] hh, ww;
   always_comb begin
      hh = height_ff;
      if (height_ff == '0) hh = SIZE_W'(1);
      else if (32'(height_ff) > MAX_HEIGHT) hh = SIZE_W'(MAX_HEIGHT);
      ww = width_ff;
      if (width_ff == '0) ww = SIZE_W'(1);
      else if (32'(width_ff) > MAX_WIDTH) ww = SIZE_W'(MAX_WIDTH);
   end

   // pipeline control
   logic out_v_ff, s1_v_ff, s2_v_ff, s3_v_ff;
   logic adv, accept;
   assign adv            = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = !reset && adv;
   assign accept         = req_chan.valid && req_chan.ready;

   // stage 1: captured transfer plus mapped coordinates
   op_type                      s1_op_ff;
   logic [CH_W-1:0]             s1_ch_ff;
   logic [IDX_W-1:0]            s1_row_ff, s1_col_ff;
   logic [PIX_W-1:0]            s1_pix_ff;
   logic signed [COORD_W-1:0]   s1_cy_ff, s1_cx_ff;
   logic [PROD_W-1:0]           py, px;

   assign py = PROD_W'(req_chan.row) * PROD_W'(ratio_y_ff) + PROD_W'(ratio_y_ff >> 1);
   assign px = PROD_W'(req_chan.col) * PROD_W'(ratio_x_ff) + PROD_W'(ratio_x_ff >> 1);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_op_ff  <= op_type'(req_chan.operation);
         s1_ch_ff  <= req_chan.channel;
         s1_row_ff <= req_chan.row;
         s1_col_ff <= req_chan.col;
         s1_pix_ff <= req_chan.pixel_in;
         s1_cy_ff  <= $signed({1'b0, py}) - $signed({1'b0, HALF});
         s1_cx_ff  <= $signed({1'b0, px}) - $signed({1'b0, HALF});
      end
   end

   // stage 1 combinational: clamp, neighbours, bank addresses
   logic [ROW_W-1:0]     r0, r1;
   logic [COL_W-1:0]     c0, c1;
   logic [FRAC_BITS-1:0] fy, fx;

   always_comb begin
      logic [FRAC_BITS+ROW_W-1:0] yb;
      logic [FRAC_BITS+COL_W-1:0] xb;
      logic [PROD_W:0]            ny, nx;
      logic [PROD_W-FRAC_BITS:0]  niy, nix;
      logic [ROW_W-1:0]           rb, rn;
      logic [COL_W-1:0]           cb, cn;
      logic [ROW_W:0]             rp;
      logic [COL_W:0]             cp;
      // bilinear clamp
      if (s1_cy_ff[COORD_W-1]) yb = '0;
      else if (s1_cy_ff[PROD_W-1:0] >= (PROD_W'(hh) << FRAC_BITS))
         yb = (FRAC_BITS+ROW_W)'(hh - SIZE_W'(1)) << FRAC_BITS;
      else yb = s1_cy_ff[FRAC_BITS+ROW_W-1:0];
      if (s1_cx_ff[COORD_W-1]) xb = '0;
      else if (s1_cx_ff[PROD_W-1:0] >= (PROD_W'(ww) << FRAC_BITS))
         xb = (FRAC_BITS+COL_W)'(ww - SIZE_W'(1)) << FRAC_BITS;
      else xb = s1_cx_ff[FRAC_BITS+COL_W-1:0];
      rb = yb[FRAC_BITS+ROW_W-1:FRAC_BITS];
      cb = xb[FRAC_BITS+COL_W-1:FRAC_BITS];
      // nearest index
      ny  = {1'b0, s1_cy_ff[PROD_W-1:0]} + {1'b0, HALF};
      nx  = {1'b0, s1_cx_ff[PROD_W-1:0]} + {1'b0, HALF};
      niy = ny[PROD_W:FRAC_BITS];
      nix = nx[PROD_W:FRAC_BITS];
      if (s1_cy_ff[COORD_W-1]) rn = '0;
      else if (niy >= (PROD_W-FRAC_BITS+1)'(hh)) rn = ROW_W'(hh - SIZE_W'(1));
      else rn = niy[ROW_W-1:0];
      if (s1_cx_ff[COORD_W-1]) cn = '0;
      else if (nix >= (PROD_W-FRAC_BITS+1)'(ww)) cn = COL_W'(ww - SIZE_W'(1));
      else cn = nix[COL_W-1:0];
      rp = {1'b0, rb} + (ROW_W+1)'(1);
      cp = {1'b0, cb} + (COL_W+1)'(1);
      if (mode_ff == MODE_NEAREST) begin
         r0 = rn; r1 = rn; c0 = cn; c1 = cn; fy = '0; fx = '0;
      end else begin
         r0 = rb;
         c0 = cb;
         r1 = (SIZE_W'(rp) < hh) ? rp[ROW_W-1:0] : ROW_W'(hh - SIZE_W'(1));
         c1 = (SIZE_W'(cp) < ww) ? cp[COL_W-1:0] : COL_W'(ww - SIZE_W'(1));
         fy = yb[FRAC_BITS-1:0];
         fx = xb[FRAC_BITS-1:0];
      end
   end

   logic s1_ch_ok, wr_in_range, wr_en, rd_en;
   assign s1_ch_ok    = 32'(s1_ch_ff) < MAX_CHANNELS;
   assign wr_in_range = s1_ch_ok && (32'(s1_row_ff) < MAX_HEIGHT) && (32'(s1_col_ff) < MAX_WIDTH);
   assign wr_en = adv && s1_v_ff && (s1_op_ff == OP_WRITE) && wr_in_range;
   assign rd_en = adv && s1_v_ff && (s1_op_ff == OP_REQUEST);

   logic [BANK_AW-1:0] wr_addr;
   logic [ROW_W-1:0]   wr_row;
   logic [COL_W-1:0]   wr_col;
   assign wr_row  = s1_row_ff[ROW_W-1:0];
   assign wr_col  = s1_col_ff[COL_W-1:0];
   assign wr_addr = {s1_ch_ff[CH_AW-1:0], wr_row[ROW_W-1:1], wr_col[COL_W-1:1]};

   logic [PIX_W-1:0] bank_q [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [ROW_W-1:0]   rsel;
      logic [COL_W-1:0]   csel;
      logic [BANK_AW-1:0] raddr;
      assign rsel  = (r0[0] == b[1]) ? r0 : r1;
      assign csel  = (c0[0] == b[0]) ? c0 : c1;
      assign raddr = {s1_ch_ff[CH_AW-1:0], rsel[ROW_W-1:1], csel[COL_W-1:1]};
      rsz_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (wr_row[0] == b[1]) && (wr_col[0] == b[0])),
         .wr_addr (wr_addr),
         .wr_data (s1_pix_ff),
         .rd_en   (rd_en),
         .rd_addr (raddr),
         .rd_data (bank_q[b])
      );
   end

   // stage 2: bank data arrives, blend columns
   logic [CH_W-1:0]      s2_ch_ff;
   logic [IDX_W-1:0]     s2_row_ff, s2_col_ff;
   logic                 s2_ok_ff;
   logic [FRAC_BITS-1:0] s2_fy_ff, s2_fx_ff;
   logic [1:0]           s2_b00_ff, s2_b01_ff, s2_b10_ff, s2_b11_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ch_ff  <= s1_ch_ff;
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
         s2_ok_ff  <= s1_ch_ok;
         s2_fy_ff  <= fy;
         s2_fx_ff  <= fx;
         s2_b00_ff <= {r0[0], c0[0]};
         s2_b01_ff <= {r0[0], c1[0]};
         s2_b10_ff <= {r1[0], c0[0]};
         s2_b11_ff <= {r1[0], c1[0]};
      end
   end

   logic [WGT_W-1:0]    wx1, wx0;
   logic [ROWSUM_W:0]   top_in, bot_in;
   assign wx1 = {1'b0, s2_fx_ff};
   assign wx0 = (WGT_W'(1) << FRAC_BITS) - wx1;
   assign top_in = (ROWSUM_W+1)'(bank_q[s2_b00_ff]) * (ROWSUM_W+1)'(wx0)
                 + (ROWSUM_W+1)'(bank_q[s2_b01_ff]) * (ROWSUM_W+1)'(wx1);
   assign bot_in = (ROWSUM_W+1)'(bank_q[s2_b10_ff]) * (ROWSUM_W+1)'(wx0)
                 + (ROWSUM_W+1)'(bank_q[s2_b11_ff]) * (ROWSUM_W+1)'(wx1);

   // stage 3: blend rows
   logic [CH_W-1:0]      s3_ch_ff;
   logic [IDX_W-1:0]     s3_row_ff, s3_col_ff;
   logic                 s3_ok_ff;
   logic [FRAC_BITS-1:0] s3_fy_ff;
   logic [ROWSUM_W-1:0]  s3_top_ff, s3_bot_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ch_ff  <= s2_ch_ff;
         s3_row_ff <= s2_row_ff;
         s3_col_ff <= s2_col_ff;
         s3_ok_ff  <= s2_ok_ff;
         s3_fy_ff  <= s2_fy_ff;
         s3_top_ff <= top_in[ROWSUM_W-1:0];
         s3_bot_ff <= bot_in[ROWSUM_W-1:0];
      end
   end

   logic [WGT_W-1:0] wy1, wy0;
   logic [SUM_W-1:0] sum_in;
   logic [PIX_W-1:0] pix_in;
   assign wy1 = {1'b0, s3_fy_ff};
   assign wy0 = (WGT_W'(1) << FRAC_BITS) - wy1;
   assign sum_in = SUM_W'(s3_top_ff) * SUM_W'(wy0) + SUM_W'(s3_bot_ff) * SUM_W'(wy1)
                 + (SUM_W'(1) << (2 * FRAC_BITS - 1));
   assign pix_in = s3_ok_ff ? sum_in[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS] : '0;

   // output register
   logic [CH_W-1:0]  out_ch_ff;
   logic [IDX_W-1:0] out_row_ff, out_col_ff;
   logic [PIX_W-1:0] out_pix_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ch_ff  <= s3_ch_ff;
         out_row_ff <= s3_row_ff;
         out_col_ff <= s3_col_ff;
         out_pix_ff <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= accept;
         s2_v_ff  <= s1_v_ff && (s1_op_ff == OP_REQUEST);
         s3_v_ff  <= s2_v_ff;
         out_v_ff <= s3_v_ff;
      end
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.out_channel = out_ch_ff;
   assign rsp_chan.out_row     = out_row_ff;
   assign rsp_chan.out_col     = out_col_ff;
   assign rsp_chan.pixel_out   = out_pix_ff;

   a_rows_in_image: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (SIZE_W'(r0) < hh) && (SIZE_W'(r1) < hh))
      else $error("row neighbour outside image");
   a_cols_in_image: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (SIZE_W'(c0) < ww) && (SIZE_W'(c1) < ww))
      else $error("column neighbour outside image");
   a_neighbour_adjacent: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> ((r1 == r0) || (SIZE_W'(r1) == SIZE_W'(r0) + SIZE_W'(1)))
             && ((c1 == c0) || (SIZE_W'(c1) == SIZE_W'(c0) + SIZE_W'(1))))
      else $error("second neighbour not adjacent");
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(s3_v_ff))
      else $error("result without a request in flight");
endmodule
`default_nettype wire

// File: sim/rsz_checker.sv
`timescale 1ns / 1ps
module rsz_checker
   import rsz_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   rsz_req_if                    req,
   rsz_rsp_if                    rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    fail_count,
   output int                    pending,
   output int                    requests_checked,
   output int                    pixels_loaded
);
   typedef struct packed {
      logic [CH_W-1:0]  ch;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [PIX_W-1:0] pix;
   } scaled_pixel_type;

   localparam longint ONE  = longint'(1) << FRAC_BITS;
   localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

   logic [PIX_W-1:0]   image_mem [MAX_CHANNELS*MAX_HEIGHT*MAX_WIDTH];
   mode_type           scale_mode;
   logic [SIZE_W-1:0]  rows_cfg, cols_cfg;
   logic [RATIO_W-1:0] step_y, step_x;
   scaled_pixel_type   expected_pixels [$];

   assign pending = expected_pixels.size();

   function automatic longint src_coord(longint idx, logic [RATIO_W-1:0] ratio);
      return idx * longint'(ratio) + longint'(ratio >> 1) - HALF;
   endfunction

   function automatic longint eff_size(logic [SIZE_W-1:0] v, longint lim);
      if (v == 0) return 1;
      return (longint'(v) > lim) ? lim : longint'(v);
   endfunction

   function automatic longint pel(longint ch, longint r, longint c);
      return longint'(image_mem[(ch*MAX_HEIGHT + r)*MAX_WIDTH + c]);
   endfunction

   function automatic longint clamp_bil(longint c, longint size);
      if (c < 0) return 0;
      if (c >= (size << FRAC_BITS)) return (size - 1) << FRAC_BITS;
      return c;
   endfunction

   function automatic longint near_idx(longint c, longint size);
      longint i;
      if (c < 0) return 0;
      i = (c + HALF) >>> FRAC_BITS;
      return (i >= size) ? size - 1 : i;
   endfunction

   function automatic logic [PIX_W-1:0] scaled_value(longint ch, longint row, longint col);
      longint hh, ww, cy, cx, y, x, r0, c0, r1, c1, fy, fx, top, bot, sum;
      hh = eff_size(rows_cfg, MAX_HEIGHT);
      ww = eff_size(cols_cfg, MAX_WIDTH);
      cy = src_coord(row, step_y);
      cx = src_coord(col, step_x);
      if (ch >= MAX_CHANNELS) return '0;
      if (scale_mode == MODE_NEAREST) return pel(ch, near_idx(cy, hh), near_idx(cx, ww));
      y  = clamp_bil(cy, hh);
      x  = clamp_bil(cx, ww);
      r0 = y >>> FRAC_BITS;
      c0 = x >>> FRAC_BITS;
      fy = y & (ONE - 1);
      fx = x & (ONE - 1);
      r1 = (r0 + 1 < hh) ? r0 + 1 : hh - 1;
      c1 = (c0 + 1 < ww) ? c0 + 1 : ww - 1;
      top = pel(ch, r0, c0) * (ONE - fx) + pel(ch, r0, c1) * fx;
      bot = pel(ch, r1, c0) * (ONE - fx) + pel(ch, r1, c1) * fx;
      sum = (top * (ONE - fy) + bot * fy + (longint'(1) << (2*FRAC_BITS - 1)))
            >>> (2*FRAC_BITS);
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   always @(posedge clock) begin
      scaled_pixel_type want, got;
      if (reset) begin
         scale_mode <= MODE_BILINEAR;
         rows_cfg <= 7'd64;
         cols_cfg <= 7'd64;
         step_y <= 23'd65536;
         step_x <= 23'd65536;
         expected_pixels.delete();
         fail_count <= 0;
         requests_checked <= 0;
         pixels_loaded <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE:       scale_mode <= mode_type'(csr_wr_data[0]);
               CSR_SRC_HEIGHT: rows_cfg <= csr_wr_data[SIZE_W-1:0];
               CSR_SRC_WIDTH:  cols_cfg <= csr_wr_data[SIZE_W-1:0];
               CSR_RATIO_Y:    step_y <= csr_wr_data[RATIO_W-1:0];
               CSR_RATIO_X:    step_x <= csr_wr_data[RATIO_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            if (op_type'(req.operation) == OP_WRITE) begin
               if (req.row < MAX_HEIGHT && req.col < MAX_WIDTH && req.channel < MAX_CHANNELS) begin
                  image_mem[(int'(req.channel)*MAX_HEIGHT + req.row)*MAX_WIDTH + req.col]
                     = req.pixel_in;
                  pixels_loaded <= pixels_loaded + 1;
               end
            end else begin
               want.ch  = req.channel;
               want.row = req.row;
               want.col = req.col;
               want.pix = scaled_value(req.channel, req.row, req.col);
               expected_pixels.push_back(want);
            end
         end
         if (rsp.valid && rsp.ready) begin
            got = {rsp.out_channel, rsp.out_row, rsp.out_col, rsp.pixel_out};
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transfer: ch %0d row %0d col %0d pix %0d",
                           got.ch, got.row, got.col, got.pix);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               requests_checked <= requests_checked + 1;
               if (got != want) begin
                  if (fail_count < 10)
                     $display("mismatch: exp ch %0d row %0d col %0d pix %0d, got ch %0d row %0d col %0d pix %0d",
                              want.ch, want.row, want.col, want.pix,
                              got.ch, got.row, got.col, got.pix);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import rsz_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int LOAD_SPAN   = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   int                    fail_count, pending, requests_checked, pixels_loaded;
   int                    burst_left = 0;
   int                    idle_cycles = 0;
   int                    config_writes = 0;
   bit                    stimulus_done = 1'b0;

   rsz_req_if req_chan ();
   rsz_rsp_if rsp_chan ();

   image_resize_sampler uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rsz_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req              (req_chan),
      .rsp              (rsp_chan),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .requests_checked (requests_checked),
      .pixels_loaded    (pixels_loaded)
   );

   always #6 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = 1'b0;
      req_chan.channel = '0;
      req_chan.row = '0;
      req_chan.col = '0;
      req_chan.pixel_in = '0;
      rsp_chan.ready = 1'b0;
   end

   // receiver stall pattern: switches at random between always ready, random and periodic stalls
   always @(posedge clock) begin
      int unsigned cyc;
      int unsigned style;
      if (cyc % 300 == 0) style = $urandom_range(0, 3);
      cyc++;
      case (style)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_chan.ready <= ($urandom_range(0, 9) != 0);
         default: rsp_chan.ready <= ((cyc / 7) % 3 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || stimulus_done || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send(op_type op, int ch, int row, int col, int pix);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.channel <= CH_W'(ch);
      req_chan.row <= IDX_W'(row);
      req_chan.col <= IDX_W'(col);
      req_chan.pixel_in <= PIX_W'(pix);
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      config_writes++;
   endtask

   task automatic setup(mode_type m, int h, int w, int ry, int rx);
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      write_reg(CSR_SRC_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_SRC_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_RATIO_Y, CSR_DATA_W'(ry));
      write_reg(CSR_RATIO_X, CSR_DATA_W'(rx));
   endtask

   function automatic int pick_ratio();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 65536;
         2: return 4194304;
         3: return 8388607;
         4: return $urandom_range(1, 8388607);
         default: return $urandom_range(8192, 262144);
      endcase
   endfunction

   function automatic int pick_size();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return 1;
         2: return 64;
         3: return 127;
         default: return $urandom_range(2, LOAD_SPAN);
      endcase
   endfunction

   initial begin
      int h, w, ry, rx;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load the top-left block plus its entries in the last row and column of every channel;
      // sizes and ratios below keep every read inside that set
      for (int c = 0; c < MAX_CHANNELS; c++)
         for (int r = 0; r <= LOAD_SPAN; r++)
            for (int k = 0; k <= LOAD_SPAN; k++)
               send(OP_WRITE, c, (r == LOAD_SPAN) ? MAX_HEIGHT - 1 : r,
                    (k == LOAD_SPAN) ? MAX_WIDTH - 1 : k, $urandom_range(0, 255));

      // directed: corners, extremes, ignored writes, odd sizes and ratios
      send(OP_WRITE, 3, 63, 63, 8'd255);
      send(OP_WRITE, 0, 0, 0, 8'd0);
      send(OP_WRITE, 1, 64, 3, 8'd77);
      send(OP_WRITE, 2, 5, 255, 8'd99);
      send(OP_REQUEST, 0, 0, 0, 8'd0);
      send(OP_REQUEST, 3, 255, 255, 8'hFF);
      send(OP_REQUEST, 1, 63, 64, 8'd0);
      send(OP_REQUEST, 2, 5, 63, 8'd0);
      setup(MODE_NEAREST, 0, 127, 4194304, 0);
      send(OP_REQUEST, 3, 255, 255, 8'd0);
      send(OP_REQUEST, 0, 0, 0, 8'd0);
      send(OP_REQUEST, 2, 1, 200, 8'd0);
      setup(MODE_BILINEAR, 127, 1, 8388607, 32768);
      send(OP_REQUEST, 1, 255, 0, 8'd0);
      send(OP_REQUEST, 3, 0, 255, 8'd0);
      send(OP_REQUEST, 0, 128, 127, 8'd0);
      setup(MODE_BILINEAR, LOAD_SPAN, LOAD_SPAN, 21845, 98304);
      send(OP_REQUEST, 2, 170, 85, 8'd0);
      send(OP_REQUEST, 1, 2, 3, 8'd0);

      for (int ph = 0; ph < 10; ph++) begin
         // a full-height image only reads its last row under the largest ratio
         h = pick_size();
         w = pick_size();
         ry = (h > LOAD_SPAN) ? 8388607 : pick_ratio();
         rx = (w > LOAD_SPAN) ? 8388607 : pick_ratio();
         setup(mode_type'(ph % 2), h, w, ry, rx);
         for (int n = 0; n < 90; n++) begin
            if ($urandom_range(0, 9) < 3)
               send(OP_WRITE, $urandom_range(0, 3),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 63),
                    $urandom_range(0, 255));
            else
               send(OP_REQUEST, $urandom_range(0, 3),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31),
                    $urandom_range(0, 255));
         end
      end

      req_chan.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      stimulus_done = 1'b1;
      repeat (12) @(posedge clock);
      $display("covered %0d stored pixels, %0d checked results, %0d register writes",
               pixels_loaded, requests_checked, config_writes);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// File: image_resize_sampler.f
src/rsz_pkg.sv
src/rsz_req_if.sv
src/rsz_rsp_if.sv
src/rsz_ram.sv
src/image_resize_sampler.sv
sim/rsz_checker.sv
sim/testbench.sv
